FILE: design/aead_pkg.sv
// shared types and constants for the audit event admission block
package aead_pkg;

  localparam int SLOTS_DEF = 16;

  // request modes
  localparam logic [1:0] MODE_LOG   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // drop reasons
  localparam logic [1:0] DROP_NONE = 2'd0;
  localparam logic [1:0] DROP_BUSY = 2'd1;
  localparam logic [1:0] DROP_DUP  = 2'd2;

  localparam logic [15:0] WINDOW_RESET = 16'd25;
  localparam logic [15:0] BACK_LIMIT   = 16'd32767;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] payload_crc;
    logic [31:0] event_tick;
    logic [7:0]  slot_sel;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  drop_reason;
    logic [3:0]  used_slot;
    logic [31:0] event_seq;
    logic        slot_ready;
    logic [31:0] drop_total;
  } res_t;

endpackage

FILE: design/audit_event_admission_dedup.sv
// top level of the audit event admission block with duplicate suppression
// result path: a taken request goes through the request register, then the result register, to out_*
// throughput: one request per cycle while out_ready is high, set by the single admission pass between registers
// a stalled result holds in the output register, one more request waits, then in_ready drops
// reset: synchronous active-low; clears sequence, slot flags, rate record, drop count; window 25
module audit_event_admission_dedup #(
  parameter int SLOTS = aead_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_payload_crc,
  input  logic [31:0] in_event_tick,
  input  logic [7:0]  in_slot_sel,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_drop_reason,
  output logic [3:0]  out_used_slot,
  output logic [31:0] out_event_seq,
  output logic        out_slot_ready,
  output logic [31:0] out_drop_total,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_dup_window
);
  import aead_pkg::*;

  // request register
  logic req_vld_r;
  req_t req_r;
  // result register
  logic out_vld_r;
  res_t res_r;
  res_t res_nxt;
  // duplicate window
  logic [15:0] window_r;

  logic fire;

  // a request is processed when the result register is free or being drained
  assign fire     = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.mode        <= in_mode;
      req_r.payload_crc <= in_payload_crc;
      req_r.event_tick  <= in_event_tick;
      req_r.slot_sel    <= in_slot_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_dup_window;
    end
  end

  // admission decision and state
  aead_admit #(
    .SLOTS(SLOTS)
  ) u_admit (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req        (req_r),
    .dup_window (window_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_accepted    = res_r.accepted;
  assign out_drop_reason = res_r.drop_reason;
  assign out_used_slot   = res_r.used_slot;
  assign out_event_seq   = res_r.event_seq;
  assign out_slot_ready  = res_r.slot_ready;
  assign out_drop_total  = res_r.drop_total;

endmodule

FILE: design/aead_admit.sv
// admission state and per-request decision logic
module aead_admit #(
  parameter int SLOTS = aead_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  aead_pkg::req_t req,
  input  logic [15:0]    dup_window,
  output aead_pkg::res_t res
);
  import aead_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]       seq_r, seq_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOTS-1:0]  flags_r, flags_nxt;
  logic              rate_vld_r, rate_vld_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [31:0]       drop_r, drop_nxt;

  logic [15:0]       crc_low;
  logic [15:0]       tick_sc;
  logic [15:0]       fwd;
  logic              idx_ok;
  logic [SLOT_W-1:0] idx;
  logic              is_dup;

  assign crc_low = req.payload_crc[15:0];
  assign tick_sc = req.event_tick[31:16];
  assign fwd     = tick_sc - tick_r;
  assign idx_ok  = ({1'b0, req.slot_sel} < 9'(SLOTS));
  assign idx     = req.slot_sel[SLOT_W-1:0];
  assign is_dup  = rate_vld_r && (crc_low == crc_r) && (fwd < dup_window);

  always_comb begin
    seq_nxt      = seq_r;
    slot_nxt     = slot_r;
    flags_nxt    = flags_r;
    rate_vld_nxt = rate_vld_r;
    crc_nxt      = crc_r;
    tick_nxt     = tick_r;
    drop_nxt     = drop_r;
    res          = '0;
    unique case (req.mode)
      MODE_LOG: begin
        seq_nxt       = seq_r + 32'd1;
        slot_nxt      = (slot_r == SLOT_W'(SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
        res.event_seq = seq_r;
        res.used_slot = 4'(slot_r);
        if (flags_r[slot_r]) begin
          res.drop_reason = DROP_BUSY;
          drop_nxt        = drop_r + 32'd1;
        end else if (is_dup) begin
          res.drop_reason = DROP_DUP;
          drop_nxt        = drop_r + 32'd1;
        end else begin
          flags_nxt[slot_r] = 1'b1;
          res.accepted      = 1'b1;
          // record kept when the new tick is far behind the old one
          if (!rate_vld_r || (fwd <= BACK_LIMIT)) begin
            rate_vld_nxt = 1'b1;
            crc_nxt      = crc_low;
            tick_nxt     = tick_sc;
          end
        end
      end
      MODE_CLEAR: begin
        if (idx_ok) begin
          flags_nxt[idx] = 1'b0;
        end
      end
      MODE_QUERY: begin
        res.slot_ready = idx_ok && flags_r[idx];
      end
      default: begin
      end
    endcase
    res.drop_total = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= '0;
      slot_r     <= '0;
      flags_r    <= '0;
      rate_vld_r <= 1'b0;
      crc_r      <= '0;
      tick_r     <= '0;
      drop_r     <= '0;
    end else if (fire) begin
      seq_r      <= seq_nxt;
      slot_r     <= slot_nxt;
      flags_r    <= flags_nxt;
      rate_vld_r <= rate_vld_nxt;
      crc_r      <= crc_nxt;
      tick_r     <= tick_nxt;
      drop_r     <= drop_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req.mode == MODE_LOG) |=> seq_r == $past(seq_r) + 32'd1)
    else $error("sequence number did not advance on a log request");

  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (drop_r == $past(drop_r)) || (drop_r == $past(drop_r) + 32'd1))
    else $error("drop count moved by more than one");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, 8'(slot_r)} < 9'(SLOTS))
    else $error("slot pointer out of range");

  a_accept_marks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.accepted |=> flags_r[$past(slot_r)])
    else $error("accepted event did not mark its slot");
`endif

endmodule

FILE: dv/audit_event_admission_dedup_tb.sv
`timescale 1ns / 100ps
// testbench for the audit event admission block: every result checked against a prediction
module audit_event_admission_dedup_tb;
  import aead_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  // mode code the block leaves unused
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // long receiver hold-off, in cycles
  localparam int LONG_HOLD = 400;
  // cycles with no handshake at all before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // settle time after the request and result registers, plus margin
  localparam int SETTLE_CYCLES = 6;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_RHYTHM} sink_style_e;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request channel, all driven to known values from time zero
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_LOG;
  logic [31:0] in_payload_crc = '0;
  logic [31:0] in_event_tick = '0;
  logic [7:0]  in_slot_sel = '0;

  // result channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [1:0]  out_drop_reason;
  logic [3:0]  out_used_slot;
  logic [31:0] out_event_seq;
  logic        out_slot_ready;
  logic [31:0] out_drop_total;

  // configuration write
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_dup_window = WINDOW_RESET;

  always #10 clk = ~clk;

  audit_event_admission_dedup #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_payload_crc(in_payload_crc),
    .in_event_tick(in_event_tick),
    .in_slot_sel(in_slot_sel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_accepted(out_accepted),
    .out_drop_reason(out_drop_reason),
    .out_used_slot(out_used_slot),
    .out_event_seq(out_event_seq),
    .out_slot_ready(out_slot_ready),
    .out_drop_total(out_drop_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_dup_window(cfg_dup_window)
  );

  // ---------------------------------------------------------------------------
  // admission predictor: own copy of the block state, as after reset
  // ---------------------------------------------------------------------------
  logic [15:0]          window_now = WINDOW_RESET;
  logic [31:0]          seq_next = '0;
  logic [NUM_SLOTS-1:0] slot_full = '0;
  logic                 rec_valid = 1'b0;
  logic [15:0]          rec_crc_low = '0;
  logic [15:0]          rec_tick = '0;
  logic [31:0]          drop_count = '0;

  // predicted results, oldest first
  res_t pending_results[$];

  int mismatch_count = 0;

  // stimulus shaping
  int          gap_max = 0;
  int          burst_left = 0;
  sink_style_e sink_style = SINK_OPEN;
  int          hold_asked = 0;
  int          hold_served = 0;
  logic [31:0] tick_now = '0;
  logic [15:0] crc_lows[4];

  // works out the result of one request and moves the predicted state on
  function automatic res_t admit_event(input req_t r);
    res_t        res;
    logic [15:0] crc_low;
    logic [15:0] tick_sc;
    logic [15:0] ahead;
    int          slot;
    res = '0;
    crc_low = r.payload_crc[15:0];
    tick_sc = r.event_tick[31:16];
    // 16-bit wrapping distance from the recorded tick
    ahead = tick_sc - rec_tick;
    case (r.mode)
      MODE_LOG: begin
        slot = int'(seq_next % NUM_SLOTS);
        res.event_seq = seq_next;
        res.used_slot = 4'(slot);
        seq_next = seq_next + 32'd1;
        if (slot_full[slot]) begin
          res.drop_reason = DROP_BUSY;
          drop_count = drop_count + 32'd1;
        end else if (rec_valid && crc_low == rec_crc_low && ahead < window_now) begin
          res.drop_reason = DROP_DUP;
          drop_count = drop_count + 32'd1;
        end else begin
          slot_full[slot] = 1'b1;
          res.accepted = 1'b1;
          // a tick too far behind leaves the record as it was
          if (!rec_valid || ahead <= BACK_LIMIT) begin
            rec_valid = 1'b1;
            rec_crc_low = crc_low;
            rec_tick = tick_sc;
          end
        end
      end
      MODE_CLEAR: begin
        if (r.slot_sel < NUM_SLOTS) slot_full[r.slot_sel] = 1'b0;
      end
      MODE_QUERY: begin
        if (r.slot_sel < NUM_SLOTS) res.slot_ready = slot_full[r.slot_sel];
      end
      default: ;
    endcase
    res.drop_total = drop_count;
    return res;
  endfunction

  // random request, half of them log events built to collide on crc and tick
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.mode = MODE_SPARE;
    r.payload_crc = $urandom;
    r.event_tick = $urandom;
    r.slot_sel = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.mode = MODE_LOG;
      // reuse a small pool of crc low halves so duplicates turn up
      if ($urandom_range(0, 9) < 6) r.payload_crc[15:0] = crc_lows[$urandom_range(0, 3)];
      if ($urandom_range(0, 19) == 0) crc_lows[$urandom_range(0, 3)] = 16'($urandom);
      tick_now = tick_now + {16'($urandom_range(0, 12)), 16'($urandom)};
      case ($urandom_range(0, 19))
        // step back across the limit where the record stops being replaced
        0: r.event_tick = tick_now - {16'($urandom_range(1, 40000)), 16'h0000};
        // fully random tick, left as drawn
        1: ;
        default: r.event_tick = tick_now;
      endcase
    end else if (pick < 80) begin
      r.mode = MODE_CLEAR;
      if ($urandom_range(0, 4) != 0) r.slot_sel = 8'($urandom_range(0, NUM_SLOTS - 1));
    end else if (pick < 95) begin
      r.mode = MODE_QUERY;
      if ($urandom_range(0, 4) != 0) r.slot_sel = 8'($urandom_range(0, NUM_SLOTS - 1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request sender: bursts of random length, random gaps between them
  // called at a rising edge, returns at the edge where the request went in
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t r);
    bit took;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_payload_crc <= r.payload_crc;
    in_event_tick <= r.event_tick;
    in_slot_sel <= r.slot_sel;
    // ready sampled mid-cycle, so the handshake is known before the edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pending_results.push_back(admit_event(r));
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_dup_window(input logic [15:0] w);
    bit took;
    cfg_valid <= 1'b1;
    cfg_dup_window <= w;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    window_now = w;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result sink: its own stall pattern, plus a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    int beat;
    hold_left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      beat++;
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (sink_style)
          SINK_OPEN: out_ready <= 1'b1;
          SINK_COIN: out_ready <= ($urandom_range(0, 3) != 0);
          default:   out_ready <= ((beat % 9) < 5) || ((beat % 9) == 7);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each result against the oldest prediction, field by field
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, got seq %0h",
                 $time, out_event_seq);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_accepted));
        check_field("drop_reason", 32'(want.drop_reason), 32'(out_drop_reason));
        check_field("used_slot", 32'(want.used_slot), 32'(out_used_slot));
        check_field("event_seq", want.event_seq, out_event_seq);
        check_field("slot_ready", 32'(want.slot_ready), 32'(out_slot_ready));
        check_field("drop_total", want.drop_total, out_drop_total);
      end
    end
  end

  // watchdog: counts cycles in which no handshake of any kind happens
  int idle_cycles = 0;
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("** audit_event_admission_dedup: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-built requests: window edges, stale record, out-of-range slots, full ring
  task automatic test_directed_cases();
    gap_max = 0;
    sink_style = SINK_COIN;
    // first event ever: no record yet, so no duplicate test
    send_request(req_t'{MODE_LOG, 32'h1234_0001, 32'h0100_0000, 8'd0});
    send_request(req_t'{MODE_QUERY, 32'h0, 32'h0, 8'd0});
    // query just past the ring and at the top of the index range
    send_request(req_t'{MODE_QUERY, 32'h0, 32'h0, 8'(NUM_SLOTS)});
    send_request(req_t'{MODE_QUERY, 32'h0, 32'h0, 8'hFF});
    // same crc low half, one unit later: duplicate
    send_request(req_t'{MODE_LOG, 32'hABCD_0001, 32'h0101_8000, 8'd0});
    // exactly one window ahead: not a duplicate
    send_request(req_t'{MODE_LOG, 32'h5555_0001, 32'h0119_0000, 8'd0});
    // one unit behind the record: kept, record left alone
    send_request(req_t'{MODE_LOG, 32'h0F0F_0001, 32'h0118_FFFF, 8'd0});
    // inside the window of the record that was kept
    send_request(req_t'{MODE_LOG, 32'h0000_0001, 32'h0130_0000, 8'd0});
    send_request(req_t'{MODE_LOG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0});
    // clear out of range does nothing, unused mode does nothing
    send_request(req_t'{MODE_CLEAR, 32'h0, 32'h0, 8'(NUM_SLOTS)});
    send_request(req_t'{MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    send_request(req_t'{MODE_CLEAR, 32'h0, 32'h0, 8'd0});
    send_request(req_t'{MODE_QUERY, 32'h0, 32'h0, 8'd0});
    // go round the ring until a slot still marked ready is hit again
    for (int i = 0; i < NUM_SLOTS - 3; i++)
      send_request(req_t'{MODE_LOG, {16'($urandom), 16'hC000 + 16'(i)},
                          {16'h0200 + 16'(i * 100), 16'($urandom)}, 8'd0});
  endtask

  // several windows, the extremes among them, each with its own traffic
  task automatic test_window_settings();
    logic [15:0] windows[5];
    windows = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 200)), WINDOW_RESET};
    sink_style = SINK_COIN;
    gap_max = 4;
    foreach (windows[k]) begin
      wait_for_quiet();
      write_dup_window(windows[k]);
      repeat (150) send_request(random_request());
    end
  endtask

  // bulk traffic under changing idle patterns, including a stretch with none
  task automatic test_random_traffic();
    gap_max = 0;
    sink_style = SINK_OPEN;
    repeat (200) send_request(random_request());
    gap_max = 6;
    sink_style = SINK_COIN;
    repeat (200) send_request(random_request());
    gap_max = 3;
    sink_style = SINK_RHYTHM;
    repeat (200) send_request(random_request());
    gap_max = 12;
    sink_style = SINK_COIN;
    repeat (200) send_request(random_request());
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    gap_max = 0;
    sink_style = SINK_COIN;
    hold_asked++;
    repeat (150) send_request(random_request());
  endtask

  // sender stops mid-stream until the pipe is empty, then carries on
  task automatic test_quiet_pause();
    gap_max = 5;
    sink_style = SINK_RHYTHM;
    repeat (75) send_request(random_request());
    wait_for_quiet();
    repeat (75) send_request(random_request());
  endtask

  initial begin : run_tests
    tick_now = $urandom;
    foreach (crc_lows[k]) crc_lows[k] = 16'($urandom);
    // reset held from time zero, never asserted again
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_window_settings();
    test_random_traffic();
    test_backpressure();
    test_quiet_pause();
    wait_for_quiet();
    if (mismatch_count == 0)
      $display("** audit_event_admission_dedup: PASSED **");
    else
      $display("** audit_event_admission_dedup: FAILED **");
    $finish;
  end

endmodule
